### hdl/rice_residual_bit_packer_defines.svh
// Assertion macros of the Rice residual bit packer, used by the back end.
// Depends on nothing; included by the files that carry assertions.
`ifndef RICE_RESIDUAL_BIT_PACKER_DEFINES_SVH
`define RICE_RESIDUAL_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RRBP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RRBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rrbp_pkg.sv
// Shared types and constants of the Rice residual bit packer.
// No dependencies; used by front, queue, back and top level.
package rrbp_pkg;

    // Largest quotient that is still coded
    localparam int unsigned MAX_QUOTIENT = 448;
    localparam int unsigned QUOT_W       = 9;

    // Configuration register indexes
    localparam logic CFG_RICE_PARAM = 1'b0;
    localparam logic CFG_CAPACITY   = 1'b1;

    localparam logic [4:0]  RICE_PARAM_RST = 5'd0;
    localparam logic [15:0] CAPACITY_RST   = 16'hFFFF;

    // One classified residual as handed from the front to the back
    typedef struct packed {
        logic              last;   // last residual of the frame
        logic              qerr;   // quotient above MAX_QUOTIENT
        logic [QUOT_W-1:0] quot;   // number of leading ones
        logic [31:0]       tail;   // zero stop bit and remainder, left aligned
        logic [5:0]        tlen;   // bits in tail, k + 1
    } item_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ONES,
        ST_TAIL,
        ST_FLUSH,
        ST_CLOSE
    } back_state_t;

endpackage

### hdl/rrbp_front.sv
// Front end: accepts residuals, zigzag maps them and splits the Rice code.
// Depends on rrbp_pkg.
module rrbp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [4:0]          rice_param,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,    // [31:0] residual
    input  logic                s_tlast,    // frame_last
    output logic                item_valid,
    input  logic                item_ready,
    output rrbp_pkg::item_t     item
);

    logic            valid_reg, valid_next;
    rrbp_pkg::item_t item_reg, item_next;
    logic [31:0]     zz;
    logic [31:0]     quot_full;
    logic [31:0]     rem_mask;
    logic            accept;

    // Take a new residual whenever the holding register is free or drains
    assign s_tready = !valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    // Zigzag map, then split into quotient and remainder
    always_comb begin
        zz        = s_tdata[31] ? {~s_tdata[30:0], 1'b1} : {s_tdata[30:0], 1'b0};
        quot_full = zz >> rice_param;
        rem_mask  = (32'h1 << rice_param) - 32'h1;

        item_next.last = s_tlast;
        item_next.qerr = quot_full > 32'(rrbp_pkg::MAX_QUOTIENT);
        item_next.quot = quot_full[rrbp_pkg::QUOT_W-1:0];
        item_next.tail = (zz & rem_mask) << (5'd31 - rice_param);
        item_next.tlen = {1'b0, rice_param} + 6'd1;
    end

    // Hold valid until the queue takes the transfer
    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/rrbp_queue.sv
// Short first-word-fall-through queue of classified residuals.
// Depends on rrbp_pkg; DEPTH must be 2 or more.
module rrbp_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  rrbp_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_req,
    output rrbp_pkg::item_t pop_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rrbp_pkg::item_t    entry_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_req && pop_valid;
    assign pop_item   = entry_mem[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the incoming entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/rrbp_back.sv
// Back end: writes Rice code bits into bytes, handles errors and frame close.
// Depends on rrbp_pkg and rice_residual_bit_packer_defines.svh.
`include "rice_residual_bit_packer_defines.svh"

module rrbp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [15:0]     capacity_bytes,
    input  logic            item_valid,
    output logic            item_pop,
    input  rrbp_pkg::item_t item,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,    // [7:0] out_byte, [8] frame_status,
                                        // [24:9] byte_total, [31:25] zero
    output logic            m_tlast,    // frame_done
    output logic            m_tuser     // byte_valid
);

    rrbp_pkg::back_state_t state_reg, state_next;

    logic [7:0]                  partial_reg, partial_next;
    logic [2:0]                  bitpos_reg, bitpos_next;
    logic [15:0]                 bytes_reg, bytes_next;
    logic                        err_reg, err_next;
    logic [rrbp_pkg::QUOT_W-1:0] qrem_reg, qrem_next;
    logic [31:0]                 tail_reg, tail_next;
    logic [5:0]                  tlen_reg, tlen_next;
    logic                        last_reg, last_next;

    logic                        out_vld_reg;
    logic [7:0]                  out_byte_reg;
    logic                        out_isbyte_reg;
    logic                        out_done_reg;
    logic                        out_status_reg;
    logic [15:0]                 out_total_reg;

    logic                        out_load;
    logic [7:0]                  ld_byte;
    logic                        ld_isbyte;
    logic                        ld_done;
    logic                        ld_status;
    logic [15:0]                 ld_total;

    logic        out_free;
    logic        in_ones, in_tail;
    logic [3:0]  room, take, end_pos;
    logic [7:0]  seg_mask, seg_src, merged;
    logic        cap_hit, phase_end, step;

    // Bit slice of this cycle: fill the current byte as far as possible
    always_comb begin
        out_free = !out_vld_reg || m_tready;
        in_ones  = state_reg == rrbp_pkg::ST_ONES;
        in_tail  = state_reg == rrbp_pkg::ST_TAIL;
        room     = 4'd8 - {1'b0, bitpos_reg};
        if (in_ones) begin
            take = (qrem_reg < {5'b0, room}) ? qrem_reg[3:0] : room;
        end else begin
            take = (tlen_reg < {2'b0, room}) ? tlen_reg[3:0] : room;
        end
        end_pos   = {1'b0, bitpos_reg} + take;
        seg_mask  = (8'hFF >> bitpos_reg) & ~(8'hFF >> end_pos);
        seg_src   = in_ones ? 8'hFF : tail_reg[31:24];
        merged    = partial_reg | ((seg_src >> bitpos_reg) & seg_mask);
        cap_hit   = (bitpos_reg == 3'd0) && (bytes_reg >= capacity_bytes);
        phase_end = in_ones ? (qrem_reg == {5'b0, take}) : (tlen_reg == {2'b0, take});
        step      = (in_ones || in_tail) && out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrbp_pkg::ST_IDLE: begin
                if (item_valid) begin
                    if (err_reg || item.qerr) begin
                        state_next = item.last ? rrbp_pkg::ST_CLOSE : rrbp_pkg::ST_IDLE;
                    end else begin
                        state_next = (item.quot != '0) ? rrbp_pkg::ST_ONES
                                                       : rrbp_pkg::ST_TAIL;
                    end
                end
            end
            rrbp_pkg::ST_ONES: begin
                if (step) begin
                    if (cap_hit) begin
                        state_next = last_reg ? rrbp_pkg::ST_CLOSE : rrbp_pkg::ST_IDLE;
                    end else if (phase_end) begin
                        state_next = rrbp_pkg::ST_TAIL;
                    end
                end
            end
            rrbp_pkg::ST_TAIL: begin
                if (step) begin
                    if (cap_hit) begin
                        state_next = last_reg ? rrbp_pkg::ST_CLOSE : rrbp_pkg::ST_IDLE;
                    end else if (phase_end) begin
                        state_next = last_reg ? rrbp_pkg::ST_FLUSH : rrbp_pkg::ST_IDLE;
                    end
                end
            end
            rrbp_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = rrbp_pkg::ST_CLOSE;
                end
            end
            rrbp_pkg::ST_CLOSE: begin
                if (out_free) begin
                    state_next = rrbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrbp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        item_pop     = 1'b0;
        partial_next = partial_reg;
        bitpos_next  = bitpos_reg;
        bytes_next   = bytes_reg;
        err_next     = err_reg;
        qrem_next    = qrem_reg;
        tail_next    = tail_reg;
        tlen_next    = tlen_reg;
        last_next    = last_reg;
        out_load     = 1'b0;
        ld_byte      = 8'd0;
        ld_isbyte    = 1'b0;
        ld_done      = 1'b0;
        ld_status    = 1'b0;
        ld_total     = 16'd0;
        unique case (state_reg)
            rrbp_pkg::ST_IDLE: begin
                // Pop a residual; drop it if the frame is in error or its quotient is too big
                if (item_valid) begin
                    item_pop  = 1'b1;
                    last_next = item.last;
                    qrem_next = item.quot;
                    tail_next = item.tail;
                    tlen_next = item.tlen;
                    if (!err_reg && item.qerr) begin
                        if (bitpos_reg != 3'd0) begin
                            bytes_next = bytes_reg - 16'd1;
                        end
                        partial_next = 8'd0;
                        bitpos_next  = 3'd0;
                        err_next     = 1'b1;
                    end
                end
            end
            rrbp_pkg::ST_ONES, rrbp_pkg::ST_TAIL: begin
                if (step) begin
                    if (cap_hit) begin
                        // No room for another byte: mark the frame bad
                        partial_next = 8'd0;
                        bitpos_next  = 3'd0;
                        err_next     = 1'b1;
                    end else begin
                        if (bitpos_reg == 3'd0) begin
                            bytes_next = bytes_reg + 16'd1;
                        end
                        if (end_pos[3]) begin
                            out_load     = 1'b1;
                            ld_byte      = merged;
                            ld_isbyte    = 1'b1;
                            partial_next = 8'd0;
                            bitpos_next  = 3'd0;
                        end else begin
                            partial_next = merged;
                            bitpos_next  = end_pos[2:0];
                        end
                        if (in_ones) begin
                            qrem_next = qrem_reg - {5'b0, take};
                        end else begin
                            tlen_next = tlen_reg - {2'b0, take};
                            tail_next = tail_reg << take;
                        end
                    end
                end
            end
            rrbp_pkg::ST_FLUSH: begin
                // Emit the zero-padded partial byte, if any
                if (out_free && bitpos_reg != 3'd0) begin
                    out_load     = 1'b1;
                    ld_byte      = partial_reg;
                    ld_isbyte    = 1'b1;
                    partial_next = 8'd0;
                    bitpos_next  = 3'd0;
                end
            end
            rrbp_pkg::ST_CLOSE: begin
                // Report the frame and clear its state
                if (out_free) begin
                    out_load     = 1'b1;
                    ld_done      = 1'b1;
                    ld_status    = err_reg;
                    ld_total     = bytes_reg;
                    partial_next = 8'd0;
                    bitpos_next  = 3'd0;
                    bytes_next   = 16'd0;
                    err_next     = 1'b0;
                end
            end
            default: begin
                item_pop = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrbp_pkg::ST_IDLE;
            partial_reg <= 8'd0;
            bitpos_reg  <= 3'd0;
            bytes_reg   <= 16'd0;
            err_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            bitpos_reg  <= bitpos_next;
            bytes_reg   <= bytes_next;
            err_reg     <= err_next;
            if (out_free) begin
                out_vld_reg <= out_load;
            end
        end
    end

    // Payload registers of the current residual and the output stage
    always_ff @(posedge aclk) begin
        qrem_reg <= qrem_next;
        tail_reg <= tail_next;
        tlen_reg <= tlen_next;
        last_reg <= last_next;
        if (out_load) begin
            out_byte_reg   <= ld_byte;
            out_isbyte_reg <= ld_isbyte;
            out_done_reg   <= ld_done;
            out_status_reg <= ld_status;
            out_total_reg  <= ld_total;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_status_reg, out_byte_reg};
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_isbyte_reg;

    `RRBP_ASSERT_IMPLY(a_no_byte_in_error, aclk, aresetn,
        out_load && ld_isbyte, !err_reg, "byte produced in a frame already in error")
    `RRBP_ASSERT_IMPLY(a_ones_nonzero, aclk, aresetn,
        state_reg == rrbp_pkg::ST_ONES, qrem_reg != '0, "ones phase with no ones left")
    `RRBP_ASSERT_IMPLY(a_tail_nonzero, aclk, aresetn,
        state_reg == rrbp_pkg::ST_TAIL, tlen_reg != 6'd0, "tail phase with no bits left")
    `RRBP_ASSERT_NEXT(a_close_clears, aclk, aresetn,
        state_reg == rrbp_pkg::ST_CLOSE && out_free,
        !err_reg && bytes_reg == 16'd0 && bitpos_reg == 3'd0,
        "frame state not cleared after close")

endmodule

### hdl/rice_residual_bit_packer.sv
// Throughput: a residual is popped from the queue, then written one byte slice per
// cycle in each of its ones and remainder phases while the output is free; the next
// residual is popped only after that. A frame's last residual then passes through
// the flush state (skipped once the frame is in error) and the close state.
// Reset: aresetn is synchronous, active low; it empties the queue, clears the frame
// and loads rice_param = 0, capacity_bytes = 65535.
module rice_residual_bit_packer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wr_data,
    // Residual stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] residual
    input  logic        s_tlast,    // frame_last
    // Packed byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] out_byte, [8] frame_status,
                                    // [24:9] byte_total, [31:25] zero
    output logic        m_tlast,    // frame_done
    output logic        m_tuser     // byte_valid
);

    logic [4:0]      rice_param_reg;
    logic [15:0]     capacity_reg;

    logic            fr_valid, fr_ready;
    rrbp_pkg::item_t fr_item;
    logic            qu_valid, qu_pop;
    rrbp_pkg::item_t qu_item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rice_param_reg <= rrbp_pkg::RICE_PARAM_RST;
            capacity_reg   <= rrbp_pkg::CAPACITY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rrbp_pkg::CFG_RICE_PARAM: rice_param_reg <= cfg_wr_data[4:0];
                rrbp_pkg::CFG_CAPACITY:   capacity_reg   <= cfg_wr_data;
                default:                  capacity_reg   <= capacity_reg;
            endcase
        end
    end

    rrbp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rice_param (rice_param_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    rrbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (qu_valid),
        .pop_req    (qu_pop),
        .pop_item   (qu_item)
    );

    rrbp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .capacity_bytes (capacity_reg),
        .item_valid     (qu_valid),
        .item_pop       (qu_pop),
        .item           (qu_item),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser)
    );

endmodule
